// File: src/bsfp_pkg.sv
package bsfp_pkg;

  localparam int unsigned CodeW  = 5;
  localparam int unsigned ValueW = 33;
  localparam int unsigned NumFields = 19;

  typedef enum logic [CodeW-1:0] {
    CodeId       = 5'd0,
    CodeCells    = 5'd1,
    CodeVoltage  = 5'd2,
    CodeTempBase = 5'd3,
    CodeCurrent  = 5'd7,
    CodeChem     = 5'd20,
    CodeAverage  = 5'd22,
    CodeMaxCell  = 5'd23,
    CodeMinCell  = 5'd24,
    CodeDelta    = 5'd25,
    CodeStatus   = 5'd26
  } item_code_e;

  typedef enum logic [2:0] {
    StIdle, StDiv, StAvg, StMax, StMin, StDelta, StStat
  } back_state_e;

  localparam logic [7:0] HeadByte0 = 8'h4E;
  localparam logic [7:0] HeadByte1 = 8'h57;
  localparam logic [15:0] MinLength = 16'd21;
  localparam logic [16:0] MinFrame = 17'd23;

  typedef struct packed {
    logic                is_end;
    logic                has_ev;
    logic [CodeW-1:0]    code;
    logic [ValueW-1:0]   value;
    logic [7:0]          label;
    logic                hdr_ok;
    logic                chk_ok;
    logic [20:0]         vtotal;
    logic [5:0]          cells;
    logic [7:0]          hi_label;
    logic [7:0]          lo_label;
    logic [15:0]         delta;
  } job_t;

  function automatic logic [7:0] fld_off(input logic [4:0] k);
    logic [7:0] r;
    case (k)
      5'd0: r = 8'd2;    5'd1: r = 8'd5;    5'd2: r = 8'd8;    5'd3: r = 8'd11;
      5'd4: r = 8'd14;   5'd5: r = 8'd16;   5'd6: r = 8'd18;   5'd7: r = 8'd21;
      5'd8: r = 8'd26;   5'd9: r = 8'd32;   5'd10: r = 8'd35;  5'd11: r = 8'd38;
      5'd12: r = 8'd41;  5'd13: r = 8'd65;  5'd14: r = 8'd71;  5'd15: r = 8'd82;
      5'd16: r = 8'd122; 5'd17: r = 8'd131; 5'd18: r = 8'd137;
      default: r = 8'd255;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] fld_len(input logic [4:0] k);
    logic [2:0] r;
    case (k)
      5'd5, 5'd6, 5'd15, 5'd17, 5'd18: r = 3'd1;
      5'd8, 5'd16: r = 3'd4;
      default: r = 3'd2;
    endcase
    return r;
  endfunction

endpackage

// File: src/bsfp_if.sv
interface bsfp_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/bsfp_front.sv
module bsfp_front #(
  parameter int unsigned MaxCells = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              frame_end_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output bsfp_pkg::job_t    job_o
);
  import bsfp_pkg::*;

  logic [15:0] pos_q, len_q, sum_q, rchk_q, hiv_q, lov_q;
  logic [31:0] shift_q;
  logic [5:0]  cells_q;
  logic [20:0] vtot_q;
  logic [7:0]  hil_q, lol_q;
  logic        hdr_q;
  logic [6:0]  ci_q;

  logic [15:0] pos_d, len_d, sum_d, rchk_d, hiv_d, lov_d;
  logic [31:0] shift_d;
  logic [5:0]  cells_d;
  logic [20:0] vtot_d;
  logic [7:0]  hil_d, lol_d;
  logic        hdr_d;
  logic [6:0]  ci_d;
  job_t        job;

  logic fire;
  assign in_ready_o = job_ready_i;
  assign fire = in_valid_i && in_ready_o;

  function automatic logic [15:0] ck_sum(input logic [15:0] s, input logic [16:0] idx,
                                         input logic [15:0] len, input logic [7:0] b);
    logic [15:0] r;
    r = s;
    if (idx + 17'd2 < {1'b0, len}) r = s + {8'd0, b};
    return r;
  endfunction

  function automatic logic [15:0] ck_rx(input logic [15:0] c, input logic [16:0] idx,
                                        input logic [15:0] len, input logic [7:0] b);
    logic [15:0] r;
    r = c;
    if (idx == {1'b0, len}) r = {b, r[7:0]};
    if (idx == {1'b0, len} + 17'd1) r = {r[15:8], b};
    return r;
  endfunction

  always_comb begin
    logic [15:0] idx;
    logic [16:0] rel, off, span;
    logic [7:0]  lb;
    logic [15:0] v, raw16;
    logic [31:0] raw;
    logic [6:0]  c;
    logic [15:0] prod;
    logic signed [17:0] s;
    pos_d = pos_q; len_d = len_q; sum_d = sum_q; rchk_d = rchk_q;
    hiv_d = hiv_q; lov_d = lov_q; shift_d = shift_q; cells_d = cells_q;
    vtot_d = vtot_q; hil_d = hil_q; lol_d = lol_q; hdr_d = hdr_q; ci_d = ci_q;
    job = '0;
    idx = pos_q;
    rel = '0; off = '0; span = '0; lb = '0; v = '0; raw16 = '0; raw = '0; c = '0; s = '0;
    prod = '0;
    if (fire) begin
      if (pos_q != 16'hFFFF) begin
        if (idx == 16'd0) begin
          len_d = '0; sum_d = '0; rchk_d = '0; cells_d = '0; vtot_d = '0;
          lov_d = '0; hiv_d = '0; lol_d = '0; hil_d = '0; hdr_d = 1'b0; ci_d = '0;
        end
        shift_d = {shift_q[23:0], rx_byte_i};
        pos_d = pos_q + 16'd1;
        if (idx == 16'd3) begin
          len_d = shift_d[15:0];
          hdr_d = shift_d[31:24] == HeadByte0 && shift_d[23:16] == HeadByte1 &&
                  shift_d[15:0] > MinLength;
          sum_d = 16'd0; rchk_d = 16'd0;
          for (int k = 0; k < 4; k++) begin
            lb = shift_d[8*(3-k) +: 8];
            sum_d = ck_sum(sum_d, 17'(k), len_d, lb);
            rchk_d = ck_rx(rchk_d, 17'(k), len_d, lb);
          end
        end else if (idx > 16'd3) begin
          sum_d = ck_sum(sum_q, {1'b0, idx}, len_q, rx_byte_i);
          rchk_d = ck_rx(rchk_q, {1'b0, idx}, len_q, rx_byte_i);
        end
        if (idx == 16'd7) begin
          job.has_ev = 1'b1; job.code = CodeId;
          job.value = {9'd0, shift_d[23:0]};
        end else if (idx == 16'd12) begin
          prod = {8'd0, rx_byte_i} * 16'd171;
          c = prod[15:9];
          if (c > 7'(MaxCells)) c = 7'(MaxCells);
          cells_d = c[5:0];
          job.has_ev = 1'b1; job.code = CodeCells; job.value = {26'd0, c};
        end else if (idx >= 16'd13) begin
          rel = {1'b0, idx} - 17'd13;
          span = 17'(cells_q) * 17'd3;
          if (rel < span) begin
            if (ci_q[1:0] == 2'd2) begin
              v = shift_d[15:0];
              lb = shift_d[23:16];
              vtot_d = vtot_q + {5'd0, v};
              if (ci_q[6:2] == 5'd0 || v > hiv_q) begin hiv_d = v; hil_d = lb; end
              if (ci_q[6:2] == 5'd0 || v < lov_q) begin lov_d = v; lol_d = lb; end
              job.has_ev = 1'b1; job.code = CodeVoltage;
              job.value = {17'd0, v}; job.label = lb;
              ci_d = {ci_q[6:2] + 5'd1, 2'd0};
            end else begin
              ci_d = ci_q + 7'd1;
            end
          end else begin
            off = rel - span;
            for (int k = NumFields - 1; k >= 0; k--) begin
              if ({9'd0, fld_off(5'(k))} == off) begin
                raw = shift_d;
                case (fld_len(5'(k)))
                  3'd1: raw = {24'd0, shift_d[7:0]};
                  3'd2: raw = {16'd0, shift_d[15:0]};
                  default: raw = shift_d;
                endcase
                raw16 = raw[15:0];
                job.has_ev = 1'b1;
                job.code = CodeTempBase + 5'(k);
                job.value = {1'b0, raw};
                if (k <= 2) begin
                  s = 18'(signed'(raw16));
                  if (s > 18'sd100) s = 18'sd100 - s;
                  job.value = 33'(s);
                end else if (k == 4) begin
                  job.value = raw16[15] ? {18'd0, raw16[14:0]}
                                        : -{18'd0, raw16[14:0]};
                end else if (k == 17) begin
                  job.value = (raw <= 32'd2) ? {1'b0, raw} : 33'd3;
                end
              end
            end
          end
        end
      end
      if (frame_end_i) begin
        job.is_end = 1'b1;
        job.has_ev = 1'b0;
        job.vtotal = vtot_d;
        job.cells = cells_d;
        job.hi_label = hil_d;
        job.lo_label = lol_d;
        job.delta = hiv_d - lov_d;
        job.hdr_ok = hdr_d;
        job.chk_ok = {1'b0, pos_d} >= MinFrame && {1'b0, pos_d} >= {1'b0, len_d} + 17'd2
                     && sum_d == rchk_d;
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; len_q <= '0; sum_q <= '0; rchk_q <= '0; hiv_q <= '0; lov_q <= '0;
      shift_q <= '0; cells_q <= '0; vtot_q <= '0; hil_q <= '0; lol_q <= '0;
      hdr_q <= 1'b0; ci_q <= '0;
    end else begin
      pos_q <= pos_d; len_q <= len_d; sum_q <= sum_d; rchk_q <= rchk_d;
      hiv_q <= hiv_d; lov_q <= lov_d; shift_q <= shift_d; cells_q <= cells_d;
      vtot_q <= vtot_d; hil_q <= hil_d; lol_q <= lol_d; hdr_q <= hdr_d; ci_q <= ci_d;
    end
  end

  assign job_valid_o = fire && (job.is_end || job.has_ev);
  assign job_o = job;
endmodule

// File: src/bsfp_queue.sv
module bsfp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  bsfp_pkg::job_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output bsfp_pkg::job_t rd_data_o
);
  import bsfp_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// File: src/bsfp_back.sv
module bsfp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  bsfp_pkg::job_t    job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [4:0]        item_code_o,
  output logic [32:0]       item_value_o,
  output logic [7:0]        cell_label_o,
  output logic              frame_done_o
);
  import bsfp_pkg::*;

  back_state_e state_q, state_d;
  job_t        job_q, job_d;
  logic [20:0] quo_q, quo_d, rem_q, rem_d;
  logic [4:0]  bit_q, bit_d;
  logic        ov_q, ov_d;
  logic [4:0]  code_q, code_d;
  logic [32:0] val_q, val_d;
  logic [7:0]  lab_q, lab_d;
  logic        done_q, done_d;

  logic out_free;
  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    logic [21:0] trial;
    state_d = state_q; job_d = job_q; quo_d = quo_q; rem_d = rem_q; bit_d = bit_q;
    ov_d = ov_q && !out_ready_i;
    code_d = code_q; val_d = val_q; lab_d = lab_q; done_d = done_q;
    job_ready_o = 1'b0;
    trial = '0;
    unique case (state_q)
      StIdle: begin
        job_ready_o = out_free;
        if (job_valid_i && out_free) begin
          if (job_i.is_end) begin
            job_d = job_i; quo_d = job_i.vtotal; rem_d = '0; bit_d = 5'd20;
            state_d = StDiv;
          end else begin
            ov_d = 1'b1; code_d = job_i.code; val_d = job_i.value;
            lab_d = job_i.label; done_d = 1'b0;
          end
        end
      end
      StDiv: begin
        trial = {rem_q, quo_q[20]} - {16'd0, job_q.cells};
        if (!trial[21]) begin
          rem_d = trial[20:0]; quo_d = {quo_q[19:0], 1'b1};
        end else begin
          rem_d = {rem_q[19:0], quo_q[20]}; quo_d = {quo_q[19:0], 1'b0};
        end
        bit_d = bit_q - 5'd1;
        if (bit_q == 5'd0) state_d = StAvg;
      end
      StAvg: if (out_free) begin
        ov_d = 1'b1; code_d = CodeAverage; lab_d = '0; done_d = 1'b0;
        val_d = (job_q.cells == '0) ? '0 : {12'd0, quo_q};
        state_d = StMax;
      end
      StMax: if (out_free) begin
        ov_d = 1'b1; code_d = CodeMaxCell; val_d = {25'd0, job_q.hi_label};
        state_d = StMin;
      end
      StMin: if (out_free) begin
        ov_d = 1'b1; code_d = CodeMinCell; val_d = {25'd0, job_q.lo_label};
        state_d = StDelta;
      end
      StDelta: if (out_free) begin
        ov_d = 1'b1; code_d = CodeDelta; val_d = {17'd0, job_q.delta};
        state_d = StStat;
      end
      StStat: if (out_free) begin
        ov_d = 1'b1; code_d = CodeStatus; done_d = 1'b1;
        val_d = {31'd0, job_q.chk_ok, job_q.hdr_ok};
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d; quo_q <= quo_d; rem_q <= rem_d; bit_q <= bit_d;
    code_q <= code_d; val_q <= val_d; lab_q <= lab_d; done_q <= done_d;
  end

  assign out_valid_o = ov_q;
  assign item_code_o = code_q;
  assign item_value_o = val_q;
  assign cell_label_o = lab_q;
  assign frame_done_o = done_q;
endmodule

// File: src/bms_status_frame_parser.sv
// A field result is registered in the queue, then in the back end's output register; the
// closing results of a frame follow the bit-serial average divider run after the end byte.
// Throughput: one byte per cycle while the two-entry queue has room; a frame end holds
// the back end through the divider run and the closing results, longer on output stalls.
// Reset (rst_ni low) clears the frame position, all frame statistics and the queue.
module bms_status_frame_parser #(
  parameter int unsigned MAX_CELLS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  bsfp_if.sink   in_i,
  bsfp_if.source out_o
);
  import bsfp_pkg::*;

  logic job_valid, job_ready, q_valid, q_ready;
  job_t job, q_job;

  bsfp_front #(.MaxCells(MAX_CELLS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .rx_byte_i(in_i.data[7:0]), .frame_end_i(in_i.data[8]),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  bsfp_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(job_valid), .wr_ready_o(job_ready), .wr_data_i(job),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_job)
  );

  bsfp_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(q_valid), .job_ready_o(q_ready), .job_i(q_job),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .item_code_o(out_o.data[4:0]), .item_value_o(out_o.data[37:5]),
    .cell_label_o(out_o.data[45:38]), .frame_done_o(out_o.data[46])
  );
endmodule

// File: tb/tb_top.sv
module tb_top;
  import bsfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned InW = 9;
  localparam int unsigned OutW = CodeW + ValueW + 8 + 1;
  localparam int unsigned Cells = 24;
  localparam longint unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic              done;
    logic [7:0]        label;
    logic [ValueW-1:0] value;
    logic [CodeW-1:0]  code;
  } result_t;

  logic clk_i;
  logic rst_ni;

  bsfp_if #(.W(InW)) rx_if ();
  bsfp_if #(.W(OutW)) res_if ();

  bms_status_frame_parser #(.MAX_CELLS(Cells)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (rx_if.sink),
    .out_o (res_if.source)
  );

  logic [8:0] byte_q[$];
  result_t    expected_q[$];
  int         errors;
  bit         byte_taken;
  bit         stim_done;
  int         gap_left;
  int         burst_left;
  int         rdy_left;
  bit         rdy_mode;
  longint unsigned cycles;

  logic [15:0] pos;
  logic [15:0] decl_len;
  logic [15:0] sum16;
  logic [15:0] rx_chk;
  logic [4:0]  n_cells;
  logic [31:0] shift_w;
  logic [20:0] v_total;
  logic [15:0] v_low;
  logic [7:0]  lab_low;
  logic [15:0] v_high;
  logic [7:0]  lab_high;
  logic        hdr_good;

  int unsigned field_at[19] = '{2, 5, 8, 11, 14, 16, 18, 21, 26, 32, 35, 38, 41, 65, 71, 82,
                                122, 131, 137};
  int unsigned field_len[19] = '{2, 2, 2, 2, 2, 1, 1, 2, 4, 2, 2, 2, 2, 2, 2, 1, 4, 1, 1};

  function automatic void push_result(logic [CodeW-1:0] code, longint value, logic [7:0] label,
                                      logic done);
    result_t r;
    r.code = code;
    r.value = value[ValueW-1:0];
    r.label = label;
    r.done = done;
    expected_q.push_back(r);
  endfunction

  function automatic void sum_byte(int unsigned idx, logic [7:0] b);
    int unsigned len;
    len = decl_len;
    if (idx + 2 < len) sum16 = sum16 + 16'(b);
    if (idx == len) rx_chk = {b, rx_chk[7:0]};
    if (idx == len + 1) rx_chk = {rx_chk[15:8], b};
  endfunction

  function automatic longint field_value(int unsigned k, logic [31:0] raw);
    longint s;
    logic [CodeW-1:0] code;
    code = CodeTempBase + 5'(k);
    if (k <= 2) begin
      s = raw[15] ? longint'(raw[15:0]) - 65536 : longint'(raw[15:0]);
      return (s > 100) ? 100 - s : s;
    end
    if (code == CodeCurrent) begin
      return raw[15] ? longint'(raw[14:0]) : -longint'(raw[14:0]);
    end
    if (code == CodeChem) begin
      return (raw <= 2) ? longint'(raw) : 3;
    end
    return longint'(raw);
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic fend);
    int unsigned idx;
    int unsigned rel;
    int unsigned span;
    int unsigned off;
    int unsigned c;
    int unsigned cnt;
    bit ev;
    bit chk;
    logic [CodeW-1:0] ev_code;
    longint ev_val;
    logic [7:0] ev_lab;
    logic [15:0] v;
    logic [31:0] raw;
    ev = 0;
    ev_code = CodeId;
    ev_val = 0;
    ev_lab = 0;
    if (pos != 16'hFFFF) begin
      idx = pos;
      if (idx == 0) begin
        decl_len = 0; sum16 = 0; rx_chk = 0; n_cells = 0; v_total = 0;
        v_low = 0; lab_low = 0; v_high = 0; lab_high = 0; hdr_good = 0;
      end
      shift_w = {shift_w[23:0], b};
      pos = pos + 16'd1;
      if (idx == 3) begin
        decl_len = shift_w[15:0];
        hdr_good = shift_w[31:24] == HeadByte0 && shift_w[23:16] == HeadByte1 &&
                   decl_len > MinLength;
        for (int k = 0; k < 4; k++) sum_byte(k, shift_w[8*(3-k) +: 8]);
      end else if (idx > 3) begin
        sum_byte(idx, b);
      end
      if (idx == 7) begin
        ev = 1; ev_code = CodeId; ev_val = longint'(shift_w[23:0]);
      end else if (idx == 12) begin
        c = b / 3;
        if (c > Cells) c = Cells;
        n_cells = 5'(c);
        ev = 1; ev_code = CodeCells; ev_val = c;
      end else if (idx >= 13) begin
        rel = idx - 13;
        span = 3 * n_cells;
        if (rel < span) begin
          if (rel % 3 == 2) begin
            v = shift_w[15:0];
            v_total = v_total + 21'(v);
            if (rel / 3 == 0 || v > v_high) begin
              v_high = v; lab_high = shift_w[23:16];
            end
            if (rel / 3 == 0 || v < v_low) begin
              v_low = v; lab_low = shift_w[23:16];
            end
            ev = 1; ev_code = CodeVoltage; ev_val = longint'(v); ev_lab = shift_w[23:16];
          end
        end else begin
          off = rel - span;
          for (int k = 0; k < 19; k++) begin
            if (!ev && field_at[k] == off) begin
              raw = (field_len[k] == 4) ? shift_w : shift_w & ((32'd1 << (8 * field_len[k])) - 1);
              ev = 1; ev_code = CodeTempBase + 5'(k); ev_val = field_value(k, raw);
            end
          end
        end
      end
    end
    if (fend) begin
      cnt = pos;
      chk = cnt >= MinFrame && cnt >= decl_len + 2 && sum16 == rx_chk;
      push_result(CodeAverage, (n_cells != 0) ? longint'(v_total / n_cells) : 0, 0, 0);
      push_result(CodeMaxCell, longint'(lab_high), 0, 0);
      push_result(CodeMinCell, longint'(lab_low), 0, 0);
      push_result(CodeDelta, longint'(16'(v_high - v_low)), 0, 0);
      push_result(CodeStatus, longint'({chk, hdr_good}), 0, 1);
      pos = 0;
    end else if (ev) begin
      push_result(ev_code, ev_val, ev_lab, 0);
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] corner[9] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h64, 8'h65, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(1, 0)) return 8'($urandom);
    return corner[$urandom_range(8, 0)];
  endfunction

  task automatic queue_frame(int unsigned total, int unsigned cnt_byte, bit good_hdr,
                             int unsigned len, bit fix_chk);
    logic [7:0] fr[$];
    logic [15:0] s;
    for (int unsigned i = 0; i < total; i++) fr.push_back(pick_byte());
    if (good_hdr && total > 1) begin
      fr[0] = HeadByte0;
      fr[1] = HeadByte1;
    end
    if (total > 3) begin
      fr[2] = len[15:8];
      fr[3] = len[7:0];
    end
    if (total > 12) fr[12] = 8'(cnt_byte);
    if (fix_chk && len + 1 < total) begin
      s = 0;
      for (int unsigned i = 0; i + 2 < len; i++) s = s + 16'(fr[i]);
      fr[len] = s[15:8];
      fr[len + 1] = s[7:0];
    end
    for (int unsigned i = 0; i < total; i++) byte_q.push_back({i == total - 1, fr[i]});
  endtask

  task automatic queue_good(int unsigned ncells, int unsigned extra, bit full);
    int unsigned total;
    total = 13 + 3 * ncells + (full ? 139 + extra : extra);
    if (total < 23) total = 23;
    queue_frame(total, 3 * ncells + $urandom_range(2, 0), 1, total - 2, 1);
  endtask

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    int unsigned kind;
    int unsigned t;
    errors = 0;
    stim_done = 0;
    rst_ni = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    queue_frame(1, 0, 0, 0, 0);
    queue_frame(3, 0, 1, 0, 0);
    queue_frame(4, 0, 1, 21, 0);
    queue_frame(23, 0, 1, 21, 1);
    queue_frame(23, 0, 1, 22, 1);
    queue_frame(30, 255, 1, 28, 1);
    queue_frame(20, 30, 0, 18, 1);
    queue_good(1, 0, 1);

    while (byte_q.size() < 280) begin
      kind = $urandom_range(1, 0);
      t = $urandom_range(30, 14);
      if (kind == 0) begin
        queue_good($urandom_range(3, 0), $urandom_range(10, 0), 0);
      end else begin
        queue_frame(t, $urandom_range(255, 0), 1, t - 2 + $urandom_range(2, 0) - 1, 1);
      end
    end
    stim_done = 1;

    wait (byte_q.size() == 0 && !rx_if.valid && expected_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
      rx_if.data <= '0;
      res_if.ready <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
      rdy_left <= 0;
      rdy_mode <= 1'b1;
    end else begin
      if (!rx_if.valid || byte_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          rx_if.valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          rx_if.valid <= 1'b1;
          rx_if.data <= byte_q.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(40, 1);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
      if (rdy_left == 0) begin
        rdy_mode <= ~rdy_mode;
        rdy_left <= rdy_mode ? $urandom_range(5, 1) : $urandom_range(30, 1);
        res_if.ready <= ~rdy_mode;
      end else begin
        rdy_left <= rdy_left - 1;
        res_if.ready <= rdy_mode;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    byte_taken = 0;
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        byte_taken = 1;
        predict_byte(rx_if.data[7:0], rx_if.data[8]);
      end
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual code %0d value %0h", $time,
                   got.code, got.value);
        end else begin
          want = expected_q.pop_front();
          if (got.code != want.code) begin
            errors++;
            $display("%0t: item_code expected %0d actual %0d", $time, want.code, got.code);
          end
          if (got.value != want.value) begin
            errors++;
            $display("%0t: item_value (code %0d) expected %0h actual %0h", $time, want.code,
                     want.value, got.value);
          end
          if (got.label != want.label) begin
            errors++;
            $display("%0t: cell_label expected %0d actual %0d", $time, want.label, got.label);
          end
          if (got.done != want.done) begin
            errors++;
            $display("%0t: frame_done expected %0d actual %0d", $time, want.done, got.done);
          end
        end
      end
    end
  end

  initial begin
    pos = 0; decl_len = 0; sum16 = 0; rx_chk = 0; n_cells = 0; shift_w = 0; v_total = 0;
    v_low = 0; lab_low = 0; v_high = 0; lab_high = 0; hdr_good = 0;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
